// File: rtl/zkid_pkg.sv
// Shared types and constants for the Fiat-Shamir identification round block.
// No dependencies; used by zkid_modmul and zero_knowledge_id_round.
package zkid_pkg;

	// APB data and address widths, and widths of the fixed value ports
	localparam int DATA_BITS  = 32;
	localparam int ADDR_BITS  = 3;
	localparam int FIELD_BITS = 32;

	// register index, taken from paddr[2]
	localparam logic REG_MODULUS = 1'b0;
	localparam logic REG_SECRET  = 1'b1;

	// status of the serial modular multiplier
	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

	// round sequencer
	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_CHECK = 10'b00_0000_0010,
		S_RED_X = 10'b00_0000_0100,
		S_RED_S = 10'b00_0000_1000,
		S_SQ_S  = 10'b00_0001_0000,
		S_MUL_A = 10'b00_0010_0000,
		S_MUL_Y = 10'b00_0100_0000,
		S_MUL_L = 10'b00_1000_0000,
		S_MUL_R = 10'b01_0000_0000,
		S_DONE  = 10'b10_0000_0000
	} state_t;

endpackage

// File: rtl/zkid_modmul.sv
// Bit-serial modular multiplier: product = multiplicand * multiplier mod modulus.
// Depends on zkid_pkg (mul_stat_t). Multiplicand must be below the modulus.
module zkid_modmul #(
	parameter int WORD_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [WORD_BITS-1:0]  multiplicand,
	input  logic [WORD_BITS-1:0]  multiplier,
	input  logic [WORD_BITS-1:0]  modulus,
	output logic [WORD_BITS-1:0]  product,
	output zkid_pkg::mul_stat_t   stat
);

	localparam int CNT_BITS = $clog2(WORD_BITS + 1);

	logic [WORD_BITS-1:0] r_q;
	logic [WORD_BITS-1:0] u_q;
	logic [WORD_BITS-1:0] v_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 done_q;
	logic [WORD_BITS:0]   sum_r;
	logic [WORD_BITS:0]   sum_u;
	logic [WORD_BITS:0]   n_ext;
	logic [WORD_BITS-1:0] r_d;
	logic [WORD_BITS-1:0] u_d;

	// accumulate r + u and double u, both reduced once against the modulus
	assign n_ext = {1'b0, modulus};
	assign sum_r = {1'b0, r_q} + {1'b0, u_q};
	assign sum_u = {1'b0, u_q} + {1'b0, u_q};

	always_comb begin
		if (sum_r >= n_ext) begin
			r_d = WORD_BITS'(sum_r - n_ext);
		end else begin
			r_d = sum_r[WORD_BITS-1:0];
		end
		if (sum_u >= n_ext) begin
			u_d = WORD_BITS'(sum_u - n_ext);
		end else begin
			u_d = sum_u[WORD_BITS-1:0];
		end
	end

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_BITS'(WORD_BITS);
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_BITS'(1));
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
			end
		end
	end

	// multiplier bits enter LSB first, one per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			u_q <= multiplicand;
			v_q <= multiplier;
		end else if (cnt_q != '0) begin
			if (v_q[0]) begin
				r_q <= r_d;
			end
			u_q <= u_d;
			v_q <= v_q >> 1;
		end
	end

	assign product   = r_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

endmodule

// File: rtl/zero_knowledge_id_round.sv
// Top level of the Fiat-Shamir identification round block: APB registers,
// round sequencer and output register. Depends on zkid_pkg and zkid_modmul.
//
//   channel   handshake            word contents
//   -------   ------------------   ---------------------------------------------
//   in        in_valid/in_ready    commitment_x, challenge
//   out       out_valid/out_ready  commitment_a, response_y, public_value,
//                                  accepted, range_error
//   apb       psel/penable/pready  modulus at 0x0, secret at 0x4
//
// Every modular product runs on one shared multiplier that takes one multiplier
// bit per cycle. A round with challenge 1 needs four products (a, y, y*y, a*V);
// challenge 0 needs two. Add one product when x is not below N, and one or two
// when V must be recomputed after reset or a register write. Modulus zero goes
// straight to the done state with no product. No clearing pass after reset.
// in_ready is high only while the sequencer idles; a finished word waits in the
// output register while the next word is taken and worked on.
module zero_knowledge_id_round #(
	parameter int WORD_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input words
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [zkid_pkg::FIELD_BITS-1:0]     commitment_x,
	input  logic                                challenge,
	// result words
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [zkid_pkg::FIELD_BITS-1:0]     commitment_a,
	output logic [zkid_pkg::FIELD_BITS-1:0]     response_y,
	output logic [zkid_pkg::FIELD_BITS-1:0]     public_value,
	output logic                                accepted,
	output logic                                range_error,
	// register port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [zkid_pkg::ADDR_BITS-1:0]      paddr,
	input  logic [zkid_pkg::DATA_BITS-1:0]      pwdata,
	output logic [zkid_pkg::DATA_BITS-1:0]      prdata,
	output logic                                pready
);

	zkid_pkg::state_t     state_q;
	zkid_pkg::state_t     state_d;
	zkid_pkg::state_t     after_x;
	logic                 launch_q;

	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] secret_q;
	logic [WORD_BITS-1:0] pv_q;
	logic                 stale_q;

	logic [WORD_BITS-1:0] x_q;
	logic                 e_q;
	logic [WORD_BITS-1:0] xr_q;
	logic [WORD_BITS-1:0] sr_q;
	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] y_q;
	logic [WORD_BITS-1:0] lhs_q;
	logic [WORD_BITS-1:0] rhs_q;
	logic                 rerr_q;

	logic                 out_valid_q;
	logic [zkid_pkg::FIELD_BITS-1:0] a_out_q;
	logic [zkid_pkg::FIELD_BITS-1:0] y_out_q;
	logic [zkid_pkg::FIELD_BITS-1:0] pv_out_q;
	logic                 acc_out_q;
	logic                 rerr_out_q;

	logic                 cfg_write;
	logic                 n_zero;
	logic                 x_lt_n;
	logic                 s_lt_n;
	logic [WORD_BITS-1:0] one_n;
	logic                 out_free;
	logic                 mul_state;
	logic                 mul_start;
	logic [WORD_BITS-1:0] mul_u;
	logic [WORD_BITS-1:0] mul_v;
	logic [WORD_BITS-1:0] mul_p;
	zkid_pkg::mul_stat_t  mul_stat;

	// register port: always ready, word-aligned decode on paddr[2]
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_comb begin
		case (paddr[2])
			zkid_pkg::REG_MODULUS: prdata = zkid_pkg::DATA_BITS'(modulus_q);
			zkid_pkg::REG_SECRET:  prdata = zkid_pkg::DATA_BITS'(secret_q);
			default:               prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= WORD_BITS'(4);
			secret_q  <= WORD_BITS'(1);
		end else if (cfg_write) begin
			if (paddr[2] == zkid_pkg::REG_MODULUS) begin
				modulus_q <= WORD_BITS'(pwdata);
			end else begin
				secret_q <= WORD_BITS'(pwdata);
			end
		end
	end

	// range checks and the residue of one
	assign n_zero = (modulus_q == '0);
	assign x_lt_n = (x_q < modulus_q);
	assign s_lt_n = (secret_q < modulus_q);
	assign one_n  = WORD_BITS'(modulus_q != WORD_BITS'(1));
	assign out_free = !out_valid_q || out_ready;

	// once x is below N: refresh V if stale, else go to x squared
	always_comb begin
		if (!stale_q) begin
			after_x = zkid_pkg::S_MUL_A;
		end else if (s_lt_n) begin
			after_x = zkid_pkg::S_SQ_S;
		end else begin
			after_x = zkid_pkg::S_RED_S;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			zkid_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = zkid_pkg::S_CHECK;
				end
			end
			zkid_pkg::S_CHECK: begin
				if (n_zero) begin
					state_d = zkid_pkg::S_DONE;
				end else if (!x_lt_n) begin
					state_d = zkid_pkg::S_RED_X;
				end else begin
					state_d = after_x;
				end
			end
			zkid_pkg::S_RED_X: begin
				if (mul_stat.done) begin
					state_d = after_x;
				end
			end
			zkid_pkg::S_RED_S: begin
				if (mul_stat.done) begin
					state_d = zkid_pkg::S_SQ_S;
				end
			end
			zkid_pkg::S_SQ_S: begin
				if (mul_stat.done) begin
					state_d = zkid_pkg::S_MUL_A;
				end
			end
			zkid_pkg::S_MUL_A: begin
				if (mul_stat.done) begin
					state_d = e_q ? zkid_pkg::S_MUL_Y : zkid_pkg::S_MUL_L;
				end
			end
			zkid_pkg::S_MUL_Y: begin
				if (mul_stat.done) begin
					state_d = zkid_pkg::S_MUL_L;
				end
			end
			zkid_pkg::S_MUL_L: begin
				if (mul_stat.done) begin
					state_d = e_q ? zkid_pkg::S_MUL_R : zkid_pkg::S_DONE;
				end
			end
			zkid_pkg::S_MUL_R: begin
				if (mul_stat.done) begin
					state_d = zkid_pkg::S_DONE;
				end
			end
			zkid_pkg::S_DONE: begin
				if (out_free) begin
					state_d = zkid_pkg::S_IDLE;
				end
			end
			default: state_d = zkid_pkg::S_IDLE;
		endcase
	end

	// state register; launch a product on the first cycle of each multiply state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= zkid_pkg::S_IDLE;
			launch_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= (state_d != state_q);
		end
	end

	assign in_ready = (state_q == zkid_pkg::S_IDLE);

	// multiplier operands per state
	always_comb begin
		mul_state = 1'b1;
		mul_u     = '0;
		mul_v     = '0;
		case (state_q)
			zkid_pkg::S_RED_X: begin
				mul_u = one_n;
				mul_v = x_q;
			end
			zkid_pkg::S_RED_S: begin
				mul_u = one_n;
				mul_v = secret_q;
			end
			zkid_pkg::S_SQ_S: begin
				mul_u = sr_q;
				mul_v = sr_q;
			end
			zkid_pkg::S_MUL_A: begin
				mul_u = xr_q;
				mul_v = xr_q;
			end
			zkid_pkg::S_MUL_Y: begin
				mul_u = xr_q;
				mul_v = sr_q;
			end
			zkid_pkg::S_MUL_L: begin
				mul_u = y_q;
				mul_v = y_q;
			end
			zkid_pkg::S_MUL_R: begin
				mul_u = a_q;
				mul_v = pv_q;
			end
			default: mul_state = 1'b0;
		endcase
	end

	assign mul_start = launch_q && mul_state;

	zkid_modmul #(
		.WORD_BITS (WORD_BITS)
	) u_modmul (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (mul_start),
		.multiplicand (mul_u),
		.multiplier   (mul_v),
		.modulus      (modulus_q),
		.product      (mul_p),
		.stat         (mul_stat)
	);

	// stored V and its stale mark; any register write forces a recompute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q    <= '0;
			stale_q <= 1'b1;
		end else if (cfg_write) begin
			stale_q <= 1'b1;
		end else if (state_q == zkid_pkg::S_CHECK && n_zero) begin
			pv_q    <= '0;
			stale_q <= 1'b0;
		end else if (state_q == zkid_pkg::S_SQ_S && mul_stat.done) begin
			pv_q    <= mul_p;
			stale_q <= 1'b0;
		end
	end

	// round working registers
	always_ff @(posedge clk) begin
		case (state_q)
			zkid_pkg::S_IDLE: begin
				if (in_valid) begin
					x_q <= WORD_BITS'(commitment_x);
					e_q <= challenge;
				end
			end
			zkid_pkg::S_CHECK: begin
				rerr_q <= (x_q == '0) || !x_lt_n || (secret_q == '0) || !s_lt_n;
				xr_q   <= x_q;
				if (stale_q) begin
					sr_q <= secret_q;
				end
				if (n_zero) begin
					a_q   <= '0;
					y_q   <= '0;
					lhs_q <= '0;
					rhs_q <= '0;
				end
			end
			zkid_pkg::S_RED_X: begin
				if (mul_stat.done) begin
					xr_q <= mul_p;
				end
			end
			zkid_pkg::S_RED_S: begin
				if (mul_stat.done) begin
					sr_q <= mul_p;
				end
			end
			zkid_pkg::S_MUL_A: begin
				if (mul_stat.done) begin
					a_q <= mul_p;
					if (!e_q) begin
						y_q <= xr_q;
					end
				end
			end
			zkid_pkg::S_MUL_Y: begin
				if (mul_stat.done) begin
					y_q <= mul_p;
				end
			end
			zkid_pkg::S_MUL_L: begin
				if (mul_stat.done) begin
					lhs_q <= mul_p;
					if (!e_q) begin
						rhs_q <= a_q;
					end
				end
			end
			zkid_pkg::S_MUL_R: begin
				if (mul_stat.done) begin
					rhs_q <= mul_p;
				end
			end
			default: begin
			end
		endcase
	end

	// output register: load the word when the slot frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == zkid_pkg::S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == zkid_pkg::S_DONE && out_free) begin
			a_out_q    <= zkid_pkg::FIELD_BITS'(a_q);
			y_out_q    <= zkid_pkg::FIELD_BITS'(y_q);
			pv_out_q   <= zkid_pkg::FIELD_BITS'(pv_q);
			acc_out_q  <= (lhs_q == rhs_q) && !rerr_q;
			rerr_out_q <= rerr_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign commitment_a = a_out_q;
	assign response_y   = y_out_q;
	assign public_value = pv_out_q;
	assign accepted     = acc_out_q;
	assign range_error  = rerr_out_q;

	// a product is never launched over one still running
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_stat.busy)
		else $error("multiplier restarted while busy");

	// a finished product arrives only in a state that waits for one
	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> (state_q == zkid_pkg::S_RED_X || state_q == zkid_pkg::S_RED_S ||
			state_q == zkid_pkg::S_SQ_S || state_q == zkid_pkg::S_MUL_A ||
			state_q == zkid_pkg::S_MUL_Y || state_q == zkid_pkg::S_MUL_L ||
			state_q == zkid_pkg::S_MUL_R))
		else $error("product finished outside a multiply state");

	// every finished product moves the sequencer on
	a_done_advance: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |=> (state_q != $past(state_q)))
		else $error("sequencer ignored a finished product");

	// the y product and the V check run only for challenge one
	a_rhs_challenge: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == zkid_pkg::S_MUL_R || state_q == zkid_pkg::S_MUL_Y) |-> e_q)
		else $error("challenge-one step taken with challenge zero");

endmodule
